// ===== hdl/i2r_pkg.sv =====
`default_nettype none

package i2r_pkg;

    localparam int VALUE_W = 12;
    localparam int SYM_W   = 7;
    localparam int STEP_W  = 10;
    localparam int IDX_W   = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;
    localparam logic [IDX_W-1:0]   IDX_LAST  = 4'd12;

    localparam logic [SYM_W-1:0] CH_NONE = 7'h00;
    localparam logic [SYM_W-1:0] CH_M    = 7'h4D;
    localparam logic [SYM_W-1:0] CH_D    = 7'h44;
    localparam logic [SYM_W-1:0] CH_C    = 7'h43;
    localparam logic [SYM_W-1:0] CH_L    = 7'h4C;
    localparam logic [SYM_W-1:0] CH_X    = 7'h58;
    localparam logic [SYM_W-1:0] CH_V    = 7'h56;
    localparam logic [SYM_W-1:0] CH_I    = 7'h49;

    // One row of the greedy table: the amount taken off and the one or two
    // letters written for it, largest amount first.
    typedef struct packed {
        logic [STEP_W-1:0] amount;
        logic [SYM_W-1:0]  first;
        logic [SYM_W-1:0]  second;
        logic              pair;
    } step_t;

    function automatic step_t step_row(input logic [IDX_W-1:0] idx);
        step_t row;
        row = '{amount: 10'd0, first: CH_NONE, second: CH_NONE, pair: 1'b0};
        unique case (idx)
            4'd0:  row = '{amount: 10'd1000, first: CH_M, second: CH_NONE, pair: 1'b0};
            4'd1:  row = '{amount: 10'd900,  first: CH_C, second: CH_M,    pair: 1'b1};
            4'd2:  row = '{amount: 10'd500,  first: CH_D, second: CH_NONE, pair: 1'b0};
            4'd3:  row = '{amount: 10'd400,  first: CH_C, second: CH_D,    pair: 1'b1};
            4'd4:  row = '{amount: 10'd100,  first: CH_C, second: CH_NONE, pair: 1'b0};
            4'd5:  row = '{amount: 10'd90,   first: CH_X, second: CH_C,    pair: 1'b1};
            4'd6:  row = '{amount: 10'd50,   first: CH_L, second: CH_NONE, pair: 1'b0};
            4'd7:  row = '{amount: 10'd40,   first: CH_X, second: CH_L,    pair: 1'b1};
            4'd8:  row = '{amount: 10'd10,   first: CH_X, second: CH_NONE, pair: 1'b0};
            4'd9:  row = '{amount: 10'd9,    first: CH_I, second: CH_X,    pair: 1'b1};
            4'd10: row = '{amount: 10'd5,    first: CH_V, second: CH_NONE, pair: 1'b0};
            4'd11: row = '{amount: 10'd4,    first: CH_I, second: CH_V,    pair: 1'b1};
            4'd12: row = '{amount: 10'd1,    first: CH_I, second: CH_NONE, pair: 1'b0};
            default: row = '{amount: 10'd1,  first: CH_I, second: CH_NONE, pair: 1'b0};
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/i2r_cmp_sub.sv =====
`default_nettype none

module i2r_cmp_sub
    import i2r_pkg::*;
(
    input  wire logic [VALUE_W-1:0] rem,
    input  wire logic [STEP_W-1:0]  amount,
    output logic                    ge,
    output logic [VALUE_W-1:0]      diff
);

    logic [VALUE_W-1:0] amount_ext;

    assign amount_ext = {{(VALUE_W-STEP_W){1'b0}}, amount};
    assign ge         = (rem >= amount_ext);
    assign diff       = rem - amount_ext;

endmodule

`default_nettype wire

// ===== hdl/integer_to_roman_numeral.sv =====
// Converts one 12-bit value into its Roman numeral, one ASCII letter per output word.
// The sequencer walks the table from the largest row, registering each letter as found;
// a value of 1 steps past every other table row first. Zero or over 3999: one flagged word.
// Throughput: one item at a time, through a single compare/subtract unit; output stalls
// hold the sequencer, and the next input word is taken once the last word is registered.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
`default_nettype none

module integer_to_roman_numeral
    import i2r_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] symbol
    output logic             m_tlast,
    output logic [1:0]       m_tuser    // [0] empty_res, [1] out_of_range
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic               state_reg, state_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               empty_reg, empty_next;
    logic               oor_reg, oor_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               last_reg, last_next;
    logic [1:0]         user_reg, user_next;

    logic               s_accept;
    logic               out_free;
    logic [VALUE_W-1:0] in_value;
    step_t              row;
    logic               ge;
    logic [VALUE_W-1:0] diff;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign row      = step_row(idx_reg);

    i2r_cmp_sub u_cmp_sub (
        .rem    (rem_reg),
        .amount (row.amount),
        .ge     (ge),
        .diff   (diff)
    );

    always_comb begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        empty_next    = empty_reg;
        oor_next      = oor_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        sym_next      = sym_reg;
        last_next     = last_reg;
        user_next     = user_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_RUN;
                    rem_next   = in_value;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    empty_next = (in_value == '0);
                    oor_next   = (in_value > VALUE_MAX);
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    if (empty_reg || oor_reg) begin
                        m_tvalid_next = 1'b1;
                        sym_next      = CH_NONE;
                        last_next     = 1'b1;
                        user_next     = {oor_reg, empty_reg};
                        state_next    = ST_IDLE;
                    end else if (pend_reg) begin
                        // Second letter of a subtractive pair; the amount is already taken off.
                        m_tvalid_next = 1'b1;
                        sym_next      = row.second;
                        last_next     = (rem_reg == '0);
                        user_next     = 2'b00;
                        pend_next     = 1'b0;
                        if (rem_reg == '0) begin
                            state_next = ST_IDLE;
                        end
                    end else if (ge) begin
                        m_tvalid_next = 1'b1;
                        sym_next      = row.first;
                        last_next     = !row.pair && (diff == '0);
                        user_next     = 2'b00;
                        rem_next      = diff;
                        pend_next     = row.pair;
                        if (!row.pair && (diff == '0)) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            idx_reg      <= '0;
            empty_reg    <= 1'b0;
            oor_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            idx_reg      <= idx_next;
            empty_reg    <= empty_next;
            oor_reg      <= oor_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rem_reg  <= rem_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, sym_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    // A value that still has letters to write keeps a remainder or a pending letter.
    a_run_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && !empty_reg && !oor_reg |-> (rem_reg != '0) || pend_reg)
        else $error("sequencer running with nothing left to write");

    // The greedy walk never runs off the end of the table.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_LAST)
        else $error("table index past last row");

    // A flagged word is always alone, so it closes the run.
    a_flag_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (user_reg != 2'b00) |-> last_reg && (sym_reg == CH_NONE))
        else $error("flagged word without last or with a letter");

    // Taking an input word always starts a conversion.
    a_accept_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_RUN))
        else $error("accepted word did not start a conversion");

endmodule

`default_nettype wire
